FILE: rtl/bitmap_page_frame_allocator_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the page frame allocator
// Same-cycle and next-cycle implication checks, reporting through $error.
// ----------------------------------------------------------------------------
`ifndef BITMAP_PAGE_FRAME_ALLOCATOR_TOP_ASSERT_SVH
`define BITMAP_PAGE_FRAME_ALLOCATOR_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define BPFA_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define BPFA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/bpfa_pkg.sv
// ----------------------------------------------------------------------------
// bpfa_pkg
// Shared constants, opcodes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package bpfa_pkg;

   localparam int unsigned MAX_BLOCKS = 1048576;
   localparam int unsigned FRAME_W    = 21;
   localparam int unsigned WORD_AW    = 15;

   localparam logic [FRAME_W-1:0] MAX_FRAMES      = FRAME_W'(MAX_BLOCKS);
   localparam logic [FRAME_W-1:0] RUN_START_FRAME = FRAME_W'(64 * 32);
   localparam logic [FRAME_W-1:0] COUNT_MAX       = '1;

   localparam logic [2:0] OP_INIT       = 3'd0;
   localparam logic [2:0] OP_ALLOC_ONE  = 3'd1;
   localparam logic [2:0] OP_ALLOC_RUN  = 3'd2;
   localparam logic [2:0] OP_FREE_ONE   = 3'd3;
   localparam logic [2:0] OP_FREE_REG   = 3'd4;
   localparam logic [2:0] OP_RESERVE    = 3'd5;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_FILL,
      CMD_READ,
      CMD_FIND_ONE,
      CMD_WORD_NEXT,
      CMD_RUN_BIT,
      CMD_WALK_WR
   } dp_cmd_type;

   typedef struct packed {
      logic [2:0] op;
      logic       single;
      logic       alloc_fail;
      logic       scan_end;
      logic       word_full;
      logic       run_hit;
      logic       last_bit;
      logic       walk_end;
      logic       fill_last;
   } dp_status_type;

endpackage

FILE: rtl/bpfa_datapath.sv
// ----------------------------------------------------------------------------
// bpfa_datapath
// Frame bitmap memory, frame pointer, counters and result registers.
// ----------------------------------------------------------------------------
module bpfa_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  bpfa_pkg::dp_cmd_type    cmd,
   output bpfa_pkg::dp_status_type status,
   input  logic [2:0]              req_opcode,
   input  logic [31:0]             req_address,
   input  logic [31:0]             req_region_bytes,
   input  logic [20:0]             req_block_count,
   input  logic                    csr_we,
   input  logic [20:0]             csr_wdata,
   output logic                    rsp_success,
   output logic [31:0]             rsp_block_address,
   output logic [20:0]             rsp_used_count,
   output logic [20:0]             rsp_free_count
);
   import bpfa_pkg::*;

   logic [31:0]        mem [2**WORD_AW];
   logic [31:0]        rdata_ff;
   logic               rd_en;
   logic               wr_en;
   logic [31:0]        wdata;

   logic [2:0]         op_ff, op_in;
   logic [FRAME_W-1:0] fp_ff, fp_in;
   logic [FRAME_W-1:0] rem_ff, rem_in;
   logic [FRAME_W-1:0] cnt_ff, cnt_in;
   logic [FRAME_W-1:0] run_ff, run_in;
   logic [FRAME_W-1:0] used_ff, used_in;
   logic [FRAME_W-1:0] total_ff;
   logic               ok_ff, ok_in;
   logic [31:0]        baddr_ff, baddr_in;

   logic [FRAME_W-1:0] t_eff;
   logic [15:0]        span_words;
   logic [4:0]         zero_idx;
   logic               cur_bit;
   logic               set_mode;
   logic [FRAME_W-1:0] run_next;
   logic [FRAME_W-1:0] run_start;
   logic [31:0]        bit_mask;

   // effective total and searched span
   assign t_eff      = (total_ff > MAX_FRAMES) ? MAX_FRAMES : total_ff;
   assign span_words = t_eff[FRAME_W-1:5];

   // lowest clear bit of the read word
   always_comb begin
      zero_idx = '0;
      for (int i = 31; i >= 0; i--) begin
         if (!rdata_ff[i]) begin
            zero_idx = 5'(i);
         end
      end
   end

   assign cur_bit   = rdata_ff[fp_ff[4:0]];
   assign run_next  = run_ff + FRAME_W'(1);
   assign run_start = fp_ff - cnt_ff + FRAME_W'(1);
   assign bit_mask  = 32'(1) << fp_ff[4:0];
   assign set_mode  = (op_ff == OP_ALLOC_ONE) || (op_ff == OP_ALLOC_RUN) ||
                      (op_ff == OP_RESERVE);

   // status to the controller
   always_comb begin
      status.op         = op_ff;
      status.single     = (cnt_ff == FRAME_W'(1));
      status.alloc_fail = ((op_ff == OP_ALLOC_RUN) && (cnt_ff == '0)) ||
                          (used_ff >= t_eff) || ((t_eff - used_ff) < cnt_ff);
      status.scan_end   = (fp_ff[FRAME_W-1:5] >= span_words);
      status.word_full  = (rdata_ff == 32'hFFFF_FFFF);
      status.run_hit    = !cur_bit && (run_next == cnt_ff);
      status.last_bit   = (fp_ff[4:0] == 5'h1F);
      status.walk_end   = (rem_ff == '0) || fp_ff[FRAME_W-1];
      status.fill_last  = (fp_ff[WORD_AW+4:5] == '1);
   end

   // next-state logic per command
   always_comb begin
      op_in    = op_ff;
      fp_in    = fp_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      run_in   = run_ff;
      used_in  = used_ff;
      ok_in    = ok_ff;
      baddr_in = baddr_ff;
      rd_en    = 1'b0;
      wr_en    = 1'b0;
      wdata    = rdata_ff;
      case (cmd)
         CMD_LOAD: begin
            op_in    = req_opcode;
            run_in   = '0;
            baddr_in = '0;
            ok_in    = (req_opcode == OP_INIT) || (req_opcode == OP_FREE_ONE) ||
                       (req_opcode == OP_FREE_REG) || (req_opcode == OP_RESERVE);
            cnt_in   = (req_opcode == OP_ALLOC_ONE) ? FRAME_W'(1) : req_block_count;
            rem_in   = (req_opcode == OP_FREE_ONE) ? FRAME_W'(1) :
                       FRAME_W'(req_region_bytes[31:12]) +
                       FRAME_W'(req_region_bytes[11:0] != '0);
            if ((req_opcode == OP_INIT) || (req_opcode == OP_ALLOC_ONE)) begin
               fp_in = '0;
            end else if (req_opcode == OP_ALLOC_RUN) begin
               fp_in = (req_block_count == FRAME_W'(1)) ? '0 : RUN_START_FRAME;
            end else begin
               fp_in = {1'b0, req_address[31:12]};
            end
            if (req_opcode == OP_INIT) begin
               used_in = t_eff;
            end
         end
         CMD_FILL: begin
            wr_en = 1'b1;
            wdata = '1;
            fp_in = fp_ff + FRAME_W'(32);
         end
         CMD_READ: begin
            rd_en = 1'b1;
         end
         CMD_FIND_ONE: begin
            fp_in    = {fp_ff[FRAME_W-1:5], zero_idx};
            rem_in   = FRAME_W'(1);
            ok_in    = 1'b1;
            baddr_in = {fp_ff[19:5], zero_idx, 12'h000};
         end
         CMD_WORD_NEXT: begin
            fp_in = fp_ff + FRAME_W'(32);
         end
         CMD_RUN_BIT: begin
            run_in = cur_bit ? '0 : run_next;
            if (!cur_bit && (run_next == cnt_ff)) begin
               fp_in    = run_start;
               rem_in   = cnt_ff;
               ok_in    = 1'b1;
               baddr_in = {run_start[19:0], 12'h000};
            end else begin
               fp_in = fp_ff + FRAME_W'(1);
            end
         end
         CMD_WALK_WR: begin
            wr_en  = 1'b1;
            wdata  = set_mode ? (rdata_ff | bit_mask) : (rdata_ff & ~bit_mask);
            fp_in  = fp_ff + FRAME_W'(1);
            rem_in = rem_ff - FRAME_W'(1);
            if (op_ff == OP_FREE_ONE) begin
               if (used_ff != '0) used_in = used_ff - FRAME_W'(1);
            end else if (cur_bit != set_mode) begin
               if (set_mode) begin
                  if (used_ff != COUNT_MAX) used_in = used_ff + FRAME_W'(1);
               end else if (used_ff != '0) begin
                  used_in = used_ff - FRAME_W'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fp_ff    <= '0;
         used_ff  <= MAX_FRAMES;
         total_ff <= MAX_FRAMES;
      end else begin
         fp_ff   <= fp_in;
         used_ff <= used_in;
         if (csr_we) total_ff <= csr_wdata;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
      run_ff   <= run_in;
      ok_ff    <= ok_in;
      baddr_ff <= baddr_in;
   end

   // bitmap memory, one port read registered, one port write
   always_ff @(posedge clock) begin
      if (wr_en) mem[fp_ff[WORD_AW+4:5]] <= wdata;
      if (rd_en) rdata_ff <= mem[fp_ff[WORD_AW+4:5]];
   end

   assign rsp_success       = ok_ff;
   assign rsp_block_address = baddr_ff;
   assign rsp_used_count    = used_ff;
   assign rsp_free_count    = (used_ff < t_eff) ? (t_eff - used_ff) : '0;

endmodule

FILE: rtl/bpfa_ctrl.sv
// ----------------------------------------------------------------------------
// bpfa_ctrl
// Sequencer: clearing pass, word scans, run search and bitmap walks.
// ----------------------------------------------------------------------------
`include "bitmap_page_frame_allocator_top_assert.svh"

module bpfa_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   output logic                    rsp_valid,
   output bpfa_pkg::dp_cmd_type    cmd,
   input  bpfa_pkg::dp_status_type status
);
   import bpfa_pkg::*;

   typedef enum logic [10:0] {
      S_IDLE     = 11'b000_0000_0001,
      S_CLEAR    = 11'b000_0000_0010,
      S_DISPATCH = 11'b000_0000_0100,
      S_FILL     = 11'b000_0000_1000,
      S_SCAN_RD  = 11'b000_0001_0000,
      S_SCAN_CHK = 11'b000_0010_0000,
      S_RUN_RD   = 11'b000_0100_0000,
      S_RUN_BIT  = 11'b000_1000_0000,
      S_WALK_RD  = 11'b001_0000_0000,
      S_WALK_WR  = 11'b010_0000_0000,
      S_DONE     = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;

   // next state and datapath command
   always_comb begin
      state_in = state_ff;
      cmd      = CMD_NONE;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd      = CMD_LOAD;
               state_in = S_DISPATCH;
            end
         end
         S_CLEAR: begin
            cmd = CMD_FILL;
            if (status.fill_last) state_in = S_IDLE;
         end
         S_DISPATCH: begin
            case (status.op)
               OP_INIT: state_in = S_FILL;
               OP_ALLOC_ONE: state_in = status.alloc_fail ? S_DONE : S_SCAN_RD;
               OP_ALLOC_RUN: begin
                  if (status.alloc_fail) state_in = S_DONE;
                  else if (status.single) state_in = S_SCAN_RD;
                  else state_in = S_RUN_RD;
               end
               OP_FREE_ONE, OP_FREE_REG, OP_RESERVE: state_in = S_WALK_RD;
               default: state_in = S_DONE;
            endcase
         end
         S_FILL: begin
            cmd = CMD_FILL;
            if (status.fill_last) state_in = S_DONE;
         end
         S_SCAN_RD: begin
            if (status.scan_end) begin
               state_in = S_DONE;
            end else begin
               cmd      = CMD_READ;
               state_in = S_SCAN_CHK;
            end
         end
         S_SCAN_CHK: begin
            if (status.word_full) begin
               cmd      = CMD_WORD_NEXT;
               state_in = S_SCAN_RD;
            end else begin
               cmd      = CMD_FIND_ONE;
               state_in = S_WALK_RD;
            end
         end
         S_RUN_RD: begin
            if (status.scan_end) begin
               state_in = S_DONE;
            end else begin
               cmd      = CMD_READ;
               state_in = S_RUN_BIT;
            end
         end
         S_RUN_BIT: begin
            cmd = CMD_RUN_BIT;
            if (status.run_hit) state_in = S_WALK_RD;
            else if (status.last_bit) state_in = S_RUN_RD;
         end
         S_WALK_RD: begin
            if (status.walk_end) begin
               state_in = S_DONE;
            end else begin
               cmd      = CMD_READ;
               state_in = S_WALK_WR;
            end
         end
         S_WALK_WR: begin
            cmd      = CMD_WALK_WR;
            state_in = S_WALK_RD;
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_DONE);

   `BPFA_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid, "result strobe held")
   `BPFA_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "no busy after accept")
   `BPFA_ASSERT_SAME(a_rsp_busy, clock, reset, rsp_valid, busy, "result while idle")
   `BPFA_ASSERT_SAME(a_load_idle, clock, reset, cmd == CMD_LOAD, !busy && start,
                     "load outside an accept")

endmodule

FILE: rtl/bitmap_page_frame_allocator_top.sv
// Init fills the bitmap one word at a time; alloc one scans bitmap words;
// alloc run of more than one frame searches bit by bit from frame 2048, then marks
// the run frame by frame; free one and free/reserve region walk frame by frame.
// One transaction at a time.
// After reset a clearing pass sets every frame used; busy is high meanwhile.
// Results are a one-cycle rsp_valid strobe; the receiver cannot stall.
// ----------------------------------------------------------------------------
// bitmap_page_frame_allocator_top
// Bitmap allocator of 4 KiB physical frames with a used-frame count.
// ----------------------------------------------------------------------------
module bitmap_page_frame_allocator_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_opcode,
   input  logic [31:0] req_address,
   input  logic [31:0] req_region_bytes,
   input  logic [20:0] req_block_count,
   input  logic        csr_we,
   input  logic [20:0] csr_wdata,
   output logic        rsp_valid,
   output logic        rsp_success,
   output logic [31:0] rsp_block_address,
   output logic [20:0] rsp_used_count,
   output logic [20:0] rsp_free_count
);
   import bpfa_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   bpfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .status    (status)
   );

   bpfa_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_opcode        (req_opcode),
      .req_address       (req_address),
      .req_region_bytes  (req_region_bytes),
      .req_block_count   (req_block_count),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata),
      .rsp_success       (rsp_success),
      .rsp_block_address (rsp_block_address),
      .rsp_used_count    (rsp_used_count),
      .rsp_free_count    (rsp_free_count)
   );

endmodule

FILE: tb/sv/tb_bitmap_page_frame_allocator_top.sv
// ----------------------------------------------------------------------------
// Page frame allocator testbench
// Drives init, alloc, free and reserve commands over several frame totals,
// with and without gaps between commands. A scoreboard holds a bitmap copy
// and checks every response against its own prediction.
// ----------------------------------------------------------------------------
module tb_bitmap_page_frame_allocator_top;
   import bpfa_pkg::*;

   typedef struct {
      logic [2:0]  opcode;
      logic [31:0] address;
      logic [31:0] region_bytes;
      logic [20:0] block_count;
   } frame_req_type;

   typedef struct {
      logic        success;
      logic [31:0] block_address;
      logic [20:0] used_count;
      logic [20:0] free_count;
   } frame_rsp_type;

   // Bitmap copy plus the queue of responses it predicts
   class frame_alloc_scoreboard;
      bit [31:0]     frame_words [32768];
      int unsigned   used_frames;
      int unsigned   total_blocks;
      frame_rsp_type pending_rsp [$];
      int            fail_count;

      function new();
         foreach (frame_words[i]) frame_words[i] = '1;
         used_frames  = MAX_BLOCKS;
         total_blocks = 1048576;
         fail_count   = 0;
      endfunction

      function int unsigned eff_total();
         return (total_blocks > MAX_BLOCKS) ? MAX_BLOCKS : total_blocks;
      endfunction

      function bit frame_used(int unsigned f);
         return frame_words[f >> 5][f & 31];
      endfunction

      // lowest clear frame among whole words below the total
      function longint first_free_frame();
         int unsigned words;
         words = eff_total() / 32;
         for (int unsigned w = 0; w < words; w++) begin
            if (frame_words[w] != 32'hFFFF_FFFF)
               for (int unsigned b = 0; b < 32; b++)
                  if (!frame_words[w][b]) return w * 32 + b;
         end
         return -1;
      endfunction

      // first run of n free frames from the run search start
      function longint first_free_run(int unsigned n);
         int unsigned limit;
         int unsigned run_len;
         limit   = (eff_total() / 32) * 32;
         run_len = 0;
         for (int unsigned f = RUN_START_FRAME; f < limit; f++) begin
            if (frame_used(f)) run_len = 0;
            else begin
               run_len++;
               if (run_len == n) return f - n + 1;
            end
         end
         return -1;
      endfunction

      function void note_request(frame_req_type r);
         int unsigned   t;
         int unsigned   cnt;
         int unsigned   f;
         longint        nfr;
         longint        frame;
         bit            set_bits;
         frame_rsp_type e;
         t = eff_total();
         e.success = 1;
         e.block_address = '0;
         cnt = r.block_count;
         case (r.opcode)
            OP_INIT: begin
               foreach (frame_words[i]) frame_words[i] = '1;
               used_frames = t;
            end
            OP_ALLOC_ONE, OP_ALLOC_RUN: begin
               e.success = 0;
               if (r.opcode == OP_ALLOC_ONE) cnt = 1;
               if (cnt != 0 && used_frames < t && t - used_frames >= cnt) begin
                  frame = (cnt == 1) ? first_free_frame() : first_free_run(cnt);
                  if (frame >= 0) begin
                     for (int unsigned i = 0; i < cnt; i++)
                        frame_words[(frame + i) >> 5][(frame + i) & 31] = 1'b1;
                     used_frames = (used_frames + cnt) & 32'h1F_FFFF;
                     e.block_address = 32'(frame * 4096);
                     e.success = 1;
                  end
               end
            end
            OP_FREE_ONE: begin
               f = r.address / 4096;
               frame_words[f >> 5][f & 31] = 1'b0;
               if (used_frames != 0) used_frames--;
            end
            OP_FREE_REG, OP_RESERVE: begin
               set_bits = (r.opcode == OP_RESERVE);
               f = r.address / 4096;
               nfr = (longint'(r.region_bytes) + 4095) / 4096;
               for (longint i = 0; i < nfr; i++, f++) begin
                  if (f >= MAX_BLOCKS) break;
                  if (frame_used(f) != set_bits) begin
                     frame_words[f >> 5][f & 31] = set_bits;
                     if (set_bits) begin
                        if (used_frames < 32'h1F_FFFF) used_frames++;
                     end else if (used_frames != 0) used_frames--;
                  end
               end
            end
            default: e.success = 0;
         endcase
         e.used_count = used_frames[20:0];
         e.free_count = (used_frames < t) ? 21'(t - used_frames) : '0;
         pending_rsp.push_back(e);
      endfunction

      task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
         $display("MISMATCH %s: got %0h want %0h", what, got, want);
         fail_count++;
      endtask

      task check_response(frame_rsp_type g);
         frame_rsp_type e;
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected response", g.used_count, 0);
            return;
         end
         e = pending_rsp.pop_front();
         if (g.success !== e.success) report_mismatch("success", g.success, e.success);
         if (g.block_address !== e.block_address)
            report_mismatch("block_address", g.block_address, e.block_address);
         if (g.used_count !== e.used_count)
            report_mismatch("used_count", g.used_count, e.used_count);
         if (g.free_count !== e.free_count)
            report_mismatch("free_count", g.free_count, e.free_count);
      endtask
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic [2:0]  req_opcode = '0;
   logic [31:0] req_address = '0;
   logic [31:0] req_region_bytes = '0;
   logic [20:0] req_block_count = '0;
   logic        csr_we = 0;
   logic [20:0] csr_wdata = '0;
   logic        rsp_valid;
   logic        rsp_success;
   logic [31:0] rsp_block_address;
   logic [20:0] rsp_used_count;
   logic [20:0] rsp_free_count;

   frame_alloc_scoreboard sb = new();
   int idle_pct = 0;

   bitmap_page_frame_allocator_top i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_opcode(req_opcode), .req_address(req_address),
      .req_region_bytes(req_region_bytes), .req_block_count(req_block_count),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .rsp_valid(rsp_valid), .rsp_success(rsp_success),
      .rsp_block_address(rsp_block_address), .rsp_used_count(rsp_used_count),
      .rsp_free_count(rsp_free_count)
   );

   always #1 clock = ~clock;

   // response monitor
   always @(posedge clock) begin
      frame_rsp_type g;
      if (!reset && rsp_valid) begin
         g.success = rsp_success;
         g.block_address = rsp_block_address;
         g.used_count = rsp_used_count;
         g.free_count = rsp_free_count;
         sb.check_response(g);
      end
   end

   // one command transaction; returns at the accepting edge
   task send_cmd(logic [2:0] op, logic [31:0] addr, logic [31:0] bytes,
                 logic [20:0] cnt);
      frame_req_type r;
      r.opcode = op; r.address = addr; r.region_bytes = bytes; r.block_count = cnt;
      req_opcode <= op; req_address <= addr;
      req_region_bytes <= bytes; req_block_count <= cnt;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      sb.note_request(r);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   // wait for the block to drain, then write the frame total
   task set_total(logic [20:0] value);
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      while (busy) @(posedge clock);
      csr_we <= 1'b1; csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.total_blocks = value;
   endtask

   // random command for a phase; big totals keep traffic in the low frames
   task random_cmd(bit big, int unsigned t);
      int unsigned sel;
      int unsigned frame_hi;
      logic [31:0] addr;
      logic [31:0] bytes;
      logic [20:0] cnt;
      sel = $urandom_range(99);
      frame_hi = big ? 8191 : t + 64;
      addr = ($urandom_range(frame_hi) << 12) | $urandom_range(4095);
      if ($urandom_range(19) == 0) addr = $urandom;
      bytes = $urandom_range(8 * 4096);
      cnt = 21'($urandom_range(1, 8));
      if (sel < 20) send_cmd(OP_ALLOC_ONE, addr, bytes, cnt);
      else if (sel < 45) begin
         if ($urandom_range(19) == 0) cnt = '0;
         else if (!big && $urandom_range(9) == 0) cnt = 21'($urandom);
         else if ($urandom_range(19) == 0) cnt = 21'h1F_FFFF;
         send_cmd(OP_ALLOC_RUN, addr, bytes, cnt);
      end
      else if (sel < 65) send_cmd(OP_FREE_ONE, addr, bytes, cnt);
      else begin
         // region walks that run off the top of memory
         if ($urandom_range(19) == 0) begin
            addr = 32'hFFF0_0000 | $urandom_range(32'hF_FFFF);
            bytes = $urandom;
         end
         send_cmd((sel < 82) ? OP_FREE_REG : OP_RESERVE, addr, bytes, cnt);
      end
   endtask

   initial begin
      int unsigned totals [8];
      int unsigned t;
      bit big;
      totals = '{4096, 0, 100, 2097151, 0, 1048576, 3000, 2048};
      totals[4] = $urandom_range(2100, 4096);
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: fully used memory, corner counts, top of memory
      send_cmd(OP_ALLOC_ONE, 0, 0, 0);
      send_cmd(OP_ALLOC_RUN, 0, 0, 0);
      send_cmd(OP_FREE_ONE, 0, 0, 0);
      send_cmd(OP_ALLOC_ONE, 0, 0, 1);
      send_cmd(OP_FREE_REG, 2048 * 4096, 2048 * 4096, 0);
      send_cmd(OP_ALLOC_RUN, 0, 0, 1);
      send_cmd(OP_ALLOC_RUN, 0, 0, 5);
      send_cmd(OP_ALLOC_RUN, 0, 0, 21'h1F_FFFF);
      send_cmd(OP_ALLOC_RUN, 0, 0, 21'd1048576);
      send_cmd(OP_RESERVE, 32'hFFFF_F000, 32'hFFFF_FFFF, 0);
      send_cmd(OP_FREE_REG, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
      send_cmd(OP_FREE_ONE, 32'hFFFF_FFFF, 0, 0);
      send_cmd(OP_RESERVE, 32'hFFFF_E123, 32'h2001, 0);
      send_cmd(OP_FREE_REG, 32'h0000_5000, 0, 0);
      send_cmd(OP_FREE_ONE, 32'h0000_2FFF, 0, 0);
      send_cmd(OP_RESERVE, 32'h0000_0000, 32'h0000_3000, 0);
      send_cmd(OP_INIT, 0, 0, 0);

      // phases over frame totals and idle modes
      foreach (totals[p]) begin
         case (p % 4)
            0: idle_pct = 0;
            1: idle_pct = 69;
            2: idle_pct = 27;
            default: idle_pct = 0;
         endcase
         set_total(21'(totals[p]));
         t = sb.eff_total();
         big = (t > 8192);
         send_cmd(OP_INIT, $urandom, $urandom, 21'($urandom));
         if (big) send_cmd(OP_FREE_REG, 2048 * 4096, 2048 * 4096, 0);
         else send_cmd(OP_FREE_REG, 0, t * 4096, 0);
         repeat (152) random_cmd(big, t);
      end

      start <= 1'b0;
      @(posedge clock);
      while (sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (sb.fail_count == 0 && sb.pending_rsp.size() == 0)
         $display("tb_bitmap_page_frame_allocator_top passed");
      else
         $display("tb_bitmap_page_frame_allocator_top failed");
      $finish;
   end

   // watchdog
   initial begin
      #40000000;
      $display("tb_bitmap_page_frame_allocator_top failed");
      $finish;
   end

endmodule
